### hdl/base_alphabet_integer_parser_defines.svh
// Assertion macros for the checker file of the alphabet integer parser.
`ifndef BASE_ALPHABET_INTEGER_PARSER_DEFINES_SVH
`define BASE_ALPHABET_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BAI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BAI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bai_pkg.sv
// Shared types, character codes and register indexes of the alphabet integer parser.
`timescale 1ns / 1ps

package bai_pkg;

    localparam int MAX_BASE_DEFAULT = 16;
    localparam int MAX_SYMS         = 16;
    localparam int MIN_BASE         = 2;
    localparam int SYM_W            = 8;
    localparam int VALUE_W          = 32;
    localparam int DIGIT_W          = 4;
    localparam int BASE_W           = 5;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_IDX_W        = 2;

    typedef logic [SYM_W-1:0] sym_t;

    // Symbol k sits in bits 8k+7 down to 8k of {symbols_high, symbols_low}.
    typedef sym_t [MAX_SYMS-1:0] alphabet_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYMBOLS_LOW  = 2'd0,
        REG_SYMBOLS_HIGH = 2'd1,
        REG_BASE_SIZE    = 2'd2
    } cfg_reg_t;

    localparam sym_t CH_NUL   = 8'h00;
    localparam sym_t CH_PLUS  = 8'h2B;
    localparam sym_t CH_MINUS = 8'h2D;
    localparam sym_t CH_SPACE = 8'h20;
    localparam sym_t CH_TAB   = 8'h09;
    localparam sym_t CH_LF    = 8'h0A;
    localparam sym_t CH_VT    = 8'h0B;
    localparam sym_t CH_FF    = 8'h0C;
    localparam sym_t CH_CR    = 8'h0D;

    typedef struct packed {
        logic               is_term;
        logic               is_space;
        logic               is_sign;
        logic               is_minus;
        logic               found;
        logic [DIGIT_W-1:0] digit;
    } sym_class_t;

endpackage

### hdl/bai_if.sv
// Handshake interfaces for the byte input, result output and configuration write channels.
`timescale 1ns / 1ps

interface bai_sym_if;
    logic            valid;
    logic            ready;
    bai_pkg::sym_t   symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface bai_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [bai_pkg::VALUE_W-1:0] value;
    logic                               accepted;

    modport source (output valid, output value, output accepted, input ready);
    modport sink   (input valid, input value, input accepted, output ready);
endinterface

interface bai_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bai_pkg::CFG_IDX_W-1:0]     index;
    logic [bai_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bai_decode.sv
// Byte classifier: terminator, whitespace, sign, and digit lookup in the alphabet.
`timescale 1ns / 1ps

module bai_decode #(
    parameter int MAX_BASE = bai_pkg::MAX_BASE_DEFAULT
) (
    input  bai_pkg::sym_t                 symbol,
    input  bai_pkg::alphabet_t            alphabet,
    input  logic [bai_pkg::BASE_W-1:0]    base_size,
    output bai_pkg::sym_class_t           cls
);

    localparam int BaseW  = bai_pkg::BASE_W;
    localparam int DigitW = bai_pkg::DIGIT_W;
    localparam logic [BaseW-1:0] MaxBaseW = BaseW'(MAX_BASE);

    logic [BaseW-1:0] used;

    assign used = (base_size > MaxBaseW) ? MaxBaseW : base_size;

    always_comb
    begin
        cls          = '0;
        cls.is_term  = (symbol == bai_pkg::CH_NUL);
        cls.is_space = (symbol == bai_pkg::CH_SPACE) || (symbol == bai_pkg::CH_TAB) ||
                       (symbol == bai_pkg::CH_LF)    || (symbol == bai_pkg::CH_VT)  ||
                       (symbol == bai_pkg::CH_FF)    || (symbol == bai_pkg::CH_CR);
        cls.is_minus = (symbol == bai_pkg::CH_MINUS);
        cls.is_sign  = cls.is_minus || (symbol == bai_pkg::CH_PLUS);
        // Scan downward so that the lowest matching index wins.
        for (int i = MAX_BASE - 1; i >= 0; i--)
        begin
            if ((BaseW'(i) < used) && (alphabet[i] == symbol))
            begin
                cls.found = 1'b1;
                cls.digit = DigitW'(i);
            end
        end
    end

endmodule

### hdl/bai_alpha_check.sv
// Registered validity check of the configured digit alphabet.
`timescale 1ns / 1ps

module bai_alpha_check #(
    parameter int MAX_BASE = bai_pkg::MAX_BASE_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bai_pkg::alphabet_t            alphabet,
    input  logic [bai_pkg::BASE_W-1:0]    base_size,
    output logic                          alpha_ok_reg
);

    localparam int BaseW = bai_pkg::BASE_W;
    localparam logic [BaseW-1:0] MaxBaseW = BaseW'(MAX_BASE);
    localparam logic [BaseW-1:0] MinBaseW = BaseW'(bai_pkg::MIN_BASE);

    logic alpha_ok_next;

    always_comb
    begin
        alpha_ok_next = (base_size >= MinBaseW) && (base_size <= MaxBaseW);
        for (int i = 0; i < MAX_BASE; i++)
        begin
            if (BaseW'(i) < base_size)
            begin
                if ((alphabet[i] == bai_pkg::CH_NUL) || (alphabet[i] == bai_pkg::CH_PLUS) ||
                    (alphabet[i] == bai_pkg::CH_MINUS))
                begin
                    alpha_ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_BASE; j++)
                begin
                    if ((BaseW'(j) < base_size) && (alphabet[j] == alphabet[i]))
                    begin
                        alpha_ok_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_ok_reg <= 1'b0;
        end
        else
        begin
            alpha_ok_reg <= alpha_ok_next;
        end
    end

endmodule

### hdl/base_alphabet_integer_parser.sv
// Top level of the configurable-alphabet string to integer parser.
`timescale 1ns / 1ps

// Takes one string byte per beat and returns one signed 32-bit result beat per
// zero terminator. The block accepts a byte in every cycle unless a terminator
// waits in the decode register while the result register is full and not ready.
// A terminator's result passes through the decode register and then the result
// register, and the result register lets the input keep flowing while a result
// waits, up to the next terminator. The per-byte rate is set by the accumulator
// update, one 32-bit by 5-bit multiply-add per cycle. The alphabet check is
// registered behind the configuration registers. The user must see that
// configuration is written only while no string is in flight; the block does not enforce it.
module base_alphabet_integer_parser #(
    parameter int MAX_BASE = bai_pkg::MAX_BASE_DEFAULT
) (
    input logic           clk,
    input logic           rst_n,
    bai_sym_if.sink       sym_in,
    bai_result_if.source  result,
    bai_cfg_if.sink       cfg
);

    localparam int ValueW = bai_pkg::VALUE_W;
    localparam int BaseW  = bai_pkg::BASE_W;
    localparam int DataW  = bai_pkg::CFG_DATA_W;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_STOPPED
    } phase_t;

    logic [DataW-1:0]    symbols_low_reg;
    logic [DataW-1:0]    symbols_high_reg;
    logic [BaseW-1:0]    base_size_reg;
    bai_pkg::alphabet_t  alphabet;
    logic                alpha_ok_reg;

    bai_pkg::sym_class_t in_cls;
    bai_pkg::sym_class_t s1_cls_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_fire;
    logic                in_ready;
    logic                in_fire;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [ValueW-1:0]   acc_reg;
    logic [ValueW-1:0]   acc_next;
    logic                negative_reg;
    logic                negative_next;
    logic                rejected_reg;
    logic                rejected_next;
    logic                seen_reg;
    logic                seen_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ValueW-1:0]   value_reg;
    logic [ValueW-1:0]   value_next;
    logic                accepted_reg;
    logic                accepted_next;
    logic                string_ok;

    assign alphabet = bai_pkg::alphabet_t'({symbols_high_reg, symbols_low_reg});

    bai_decode #(
        .MAX_BASE (MAX_BASE)
    ) u_decode (
        .symbol    (sym_in.symbol),
        .alphabet  (alphabet),
        .base_size (base_size_reg),
        .cls       (in_cls)
    );

    bai_alpha_check #(
        .MAX_BASE (MAX_BASE)
    ) u_alpha_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .alphabet     (alphabet),
        .base_size    (base_size_reg),
        .alpha_ok_reg (alpha_ok_reg)
    );

    // Only a terminator needs room in the result register to move on.
    assign s1_fire  = s1_valid_reg &&
                      (!s1_cls_reg.is_term || !out_valid_reg || result.ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = sym_in.valid && in_ready;

    assign sym_in.ready    = in_ready;
    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.value    = signed'(value_reg);
    assign result.accepted = accepted_reg;

    assign string_ok = seen_reg && !rejected_reg && alpha_ok_reg;

    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        negative_next  = negative_reg;
        rejected_next  = rejected_reg;
        seen_next      = seen_reg;
        out_valid_next = (out_valid_reg && !result.ready);
        value_next     = value_reg;
        accepted_next  = accepted_reg;

        if (s1_fire)
        begin
            if (s1_cls_reg.is_term)
            begin
                out_valid_next = 1'b1;
                accepted_next  = string_ok;
                value_next     = !string_ok ? '0 :
                                 (negative_reg ? (ValueW'(0) - acc_reg) : acc_reg);
                phase_next     = PH_SPACE;
                acc_next       = '0;
                negative_next  = 1'b0;
                rejected_next  = 1'b0;
                seen_next      = 1'b0;
            end
            else
            begin
                seen_next = 1'b1;
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (!s1_cls_reg.is_space)
                        begin
                            phase_next = PH_DIGITS;
                            if (s1_cls_reg.is_sign)
                            begin
                                negative_next = s1_cls_reg.is_minus;
                            end
                            else if (!s1_cls_reg.found)
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = ValueW'(s1_cls_reg.digit);
                            end
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (s1_cls_reg.is_sign)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else if (!s1_cls_reg.found)
                        begin
                            rejected_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_reg * ValueW'(base_size_reg) +
                                       ValueW'(s1_cls_reg.digit);
                        end
                    end
                    PH_STOPPED:
                    begin
                        // After a late sign the bytes are still checked.
                        if (!s1_cls_reg.is_sign && !s1_cls_reg.found)
                        begin
                            rejected_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SPACE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
            base_size_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            phase_reg        <= PH_SPACE;
            acc_reg          <= '0;
            negative_reg     <= 1'b0;
            rejected_reg     <= 1'b0;
            seen_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    bai_pkg::REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg.data;
                    bai_pkg::REG_SYMBOLS_HIGH: symbols_high_reg <= cfg.data;
                    bai_pkg::REG_BASE_SIZE:    base_size_reg    <= cfg.data[BaseW-1:0];
                    default:                   ;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            negative_reg  <= negative_next;
            rejected_reg  <= rejected_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cls_reg <= in_cls;
        end
        value_reg    <= value_next;
        accepted_reg <= accepted_next;
    end

endmodule

### hdl/bai_checker.sv
// Port-level assertions for the alphabet integer parser, bound to its top level.
`timescale 1ns / 1ps

`include "base_alphabet_integer_parser_defines.svh"

module bai_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bai_pkg::VALUE_W-1:0]   out_value,
    input logic                          out_accepted
);

    // A result beat that is not taken stays unchanged.
    `BAI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_value) && $stable(out_accepted),
        "result beat changed while stalled")

    // A rejected string always reports zero.
    `BAI_ASSERT_IMPLY(a_reject_zero, clk, rst_n, out_valid && !out_accepted,
        out_value == '0, "rejected result with nonzero value")

    // With the result register empty nothing can hold up the input side.
    `BAI_ASSERT_IMPLY(a_in_flow, clk, rst_n, !out_valid, in_ready,
        "input stalled with empty result register")

endmodule

bind base_alphabet_integer_parser bai_checker u_bai_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (sym_in.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_value    (result.value),
    .out_accepted (result.accepted)
);
